FILE: rtl/core/etpq_pkg.sv
// Shared widths, codes and types of the event time priority queue.
package etpq_pkg;

	localparam int TIME_W    = 32;
	localparam int ID_W      = 16;
	localparam int KIND_W    = 4;
	localparam int STATUS_W  = 2;
	localparam int OCC_OUT_W = 7;

	localparam int DEFAULT_QUEUE_DEPTH = 64;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] ev_time;
		logic [ID_W-1:0]   ev_id;
		logic [KIND_W-1:0] ev_kind;
	} entry_t;

	// Broadcast command to every cell for the current cycle
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

	// What a cell shows its neighbours
	typedef struct packed {
		entry_t entry;
		logic   used;
		logic   greater;
	} cell_link_t;

	localparam cell_link_t LINK_NONE = '{entry: '0, used: 1'b0, greater: 1'b0};

endpackage

FILE: rtl/core/etpq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbours.
module etpq_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  etpq_pkg::cell_ctrl_t  ctrl,
	input  etpq_pkg::entry_t      new_entry,
	input  etpq_pkg::cell_link_t  left,
	input  etpq_pkg::cell_link_t  right,
	output etpq_pkg::cell_link_t  link
);

	etpq_pkg::entry_t entry_q;
	logic             used_q;
	logic             greater;

	// Free slot or strictly later time: the new entry belongs at or before here
	assign greater = !used_q || (entry_q.ev_time > new_entry.ev_time);

	assign link.entry   = entry_q;
	assign link.used    = used_q;
	assign link.greater = greater;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctrl.push && greater) begin
			used_q <= left.greater ? left.used : 1'b1;
		end else if (ctrl.pop) begin
			used_q <= right.used;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && greater) begin
			entry_q <= left.greater ? left.entry : new_entry;
		end else if (ctrl.pop) begin
			entry_q <= right.entry;
		end
	end

endmodule

FILE: rtl/core/event_time_priority_queue.sv
// Top level of the event time priority queue: a row of sorting cells with a result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_ready   | operation, event_time, event_id, event_kind
//  out     | source    | out_valid / out_ready | popped_valid, popped_time, popped_id,
//          |           |                      | popped_kind, status_code, occupancy_now
//
// For each item, every cell compares its time with the pushed time in
// parallel and the whole row shifts right (push) or left (pop) at the same edge.
// The result appears in the output register in the cycle after the transfer in.
// A new item is taken whenever the output register is empty or being drained, so the
// rate is one item per cycle while the consumer keeps up.
// Reset clears the used bits, the occupancy count and the output valid flag; slot payloads
// are left as they are and are never read before being written.
// A stalled output holds in_ready low until the waiting result is taken.
module event_time_priority_queue #(
	parameter int QUEUE_DEPTH = etpq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [etpq_pkg::TIME_W-1:0]       event_time,
	input  logic [etpq_pkg::ID_W-1:0]         event_id,
	input  logic [etpq_pkg::KIND_W-1:0]       event_kind,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              popped_valid,
	output logic [etpq_pkg::TIME_W-1:0]       popped_time,
	output logic [etpq_pkg::ID_W-1:0]         popped_id,
	output logic [etpq_pkg::KIND_W-1:0]       popped_kind,
	output logic [etpq_pkg::STATUS_W-1:0]     status_code,
	output logic [etpq_pkg::OCC_OUT_W-1:0]    occupancy_now
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	etpq_pkg::cell_ctrl_t ctrl;
	etpq_pkg::entry_t     new_entry;
	etpq_pkg::cell_link_t link [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] used_vec;

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] occ_next;
	logic             in_accept;
	logic             is_push;
	logic             full;
	logic             empty;

	logic                              out_valid_q;
	logic                              res_pvalid_q;
	etpq_pkg::entry_t                  res_entry_q;
	logic [etpq_pkg::STATUS_W-1:0]     res_status_q;
	logic [OCC_W-1:0]                  res_occ_q;
	logic [OCC_W+etpq_pkg::OCC_OUT_W-1:0] occ_wide;

	// Accept while the result register is free or emptying this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign is_push   = (operation == etpq_pkg::OP_PUSH);
	assign full      = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign empty     = (occ_q == '0);

	// Drop pushes into a full row and pops from an empty one
	assign ctrl.push = in_accept && is_push && !full;
	assign ctrl.pop  = in_accept && !is_push && !empty;

	assign new_entry.ev_time = event_time;
	assign new_entry.ev_id   = event_id;
	assign new_entry.ev_kind = event_kind;

	generate
		for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			etpq_pkg::cell_link_t left_link;
			etpq_pkg::cell_link_t right_link;

			if (g == 0) begin : g_head
				assign left_link = etpq_pkg::LINK_NONE;
			end else begin : g_left
				assign left_link = link[g-1];
			end

			if (g == QUEUE_DEPTH - 1) begin : g_tail
				assign right_link = etpq_pkg::LINK_NONE;
			end else begin : g_right
				assign right_link = link[g+1];
			end

			etpq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.new_entry (new_entry),
				.left      (left_link),
				.right     (right_link),
				.link      (link[g])
			);

			assign used_vec[g] = link[g].used;
		end
	endgenerate

	always_comb begin
		occ_next = occ_q;
		if (ctrl.push) begin
			occ_next = occ_q + 1'b1;
		end else if (ctrl.pop) begin
			occ_next = occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_next;
		end
	end

	// Output register: hold until transferred, reload on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_pvalid_q <= ctrl.pop;
			res_entry_q  <= ctrl.pop ? link[0].entry : '0;
			res_occ_q    <= occ_next;
			if (is_push && full) begin
				res_status_q <= etpq_pkg::STATUS_FULL;
			end else if (!is_push && empty) begin
				res_status_q <= etpq_pkg::STATUS_EMPTY;
			end else begin
				res_status_q <= etpq_pkg::STATUS_OK;
			end
		end
	end

	// Show the low bits of the count, zero-extended when the count is narrow
	assign occ_wide = {{etpq_pkg::OCC_OUT_W{1'b0}}, res_occ_q};

	assign out_valid     = out_valid_q;
	assign popped_valid  = res_pvalid_q;
	assign popped_time   = res_entry_q.ev_time;
	assign popped_id     = res_entry_q.ev_id;
	assign popped_kind   = res_entry_q.ev_kind;
	assign status_code   = res_status_q;
	assign occupancy_now = occ_wide[etpq_pkg::OCC_OUT_W-1:0];

	// Used bits track the count exactly
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_vec) == int'(occ_q))
		else $error("used bits disagree with occupancy");

	// Used slots form an unbroken run from the head
	a_used_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((used_vec >> 1) & ~used_vec) == '0)
		else $error("gap in used slots");

	// A successful push grows the queue by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> occ_q == $past(occ_q) + 1'b1)
		else $error("push did not grow occupancy");

	// A carried event only comes with an ok status
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_pvalid_q) |-> res_status_q == etpq_pkg::STATUS_OK)
		else $error("popped event with error status");

endmodule
